// File: rtl/lbb_pkg.sv
// Shared types and constants of the length bucket batcher.
`timescale 1ns / 1ps
package lbb_pkg;

    localparam int NUM_BUCKETS_DEF = 4;
    localparam int BATCH_MAX_DEF   = 16;
    localparam int RULE_REGS       = 4;
    localparam int LEN_W           = 24;
    localparam int TAG_W           = 16;
    localparam int BKT_W           = 2;
    localparam int CAP_W           = 5;
    localparam int INUSE_W         = 3;
    localparam int RULE_W          = 53;
    localparam int CFG_IDX_W       = 8;

    localparam logic [CFG_IDX_W-1:0] REG_BUCKET_IN_USE = 8'd0;
    localparam logic [CFG_IDX_W-1:0] REG_RULE_FIRST    = 8'd1;
    localparam logic [CFG_IDX_W-1:0] REG_RULE_LAST     = 8'd4;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MATCH,
        ST_SCAN_START,
        ST_SCAN,
        ST_OUT
    } state_t;

    typedef struct packed {
        logic capture;
        logic commit;
        logic scan_start;
        logic scan_step;
        logic pop;
    } cmd_t;

    typedef struct packed {
        logic hit;
        logic emit;
        logic scan_done;
        logic last;
    } status_t;

endpackage

// File: rtl/length_bucket_batcher_unit.sv
// Top level of the length bucket batcher.
`timescale 1ns / 1ps
// Usage:
//   Input channel (in_valid/in_ready, item_length, item_tag): one request per
//   item. in_ready is high only while the block is idle; an accepted item is
//   binned in the next cycle; if it completes no batch, the block is idle again.
//   An item that fits no active bucket is dropped silently.
//   When an item fills its bucket, the batch streams out on the output channel
//   (out_valid/out_ready, out_tag, out_length, out_bucket, last_of_batch),
//   longest first, equal lengths in arrival order, last_of_batch on the final
//   member. Each member is found by a selection scan over the bucket entries
//   through the single read port of the entry store: a setup state, a read of
//   each filled entry, the close of the scan, then the output state, which
//   holds the member until the receiver takes it.
//   No new item is taken until the whole batch is delivered.
//   A stalled receiver simply holds the current member on the output ports.
//   Configuration (cfg_we, cfg_index, cfg_data) is written while idle:
//   index 0 bucket_in_use, 1..4 the bucket rules; other indexes are ignored.
//   Reset clears the config registers, the fill counts and the controller;
//   the entry store needs no clearing since only written entries are read.
module length_bucket_batcher_unit
#(
    parameter int NUM_BUCKETS = lbb_pkg::NUM_BUCKETS_DEF,
    parameter int BATCH_MAX   = lbb_pkg::BATCH_MAX_DEF
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_we,
    input  logic [lbb_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [lbb_pkg::RULE_W-1:0]    cfg_data,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic [lbb_pkg::LEN_W-1:0]     item_length,
    input  logic [lbb_pkg::TAG_W-1:0]     item_tag,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [lbb_pkg::TAG_W-1:0]     out_tag,
    output logic [lbb_pkg::LEN_W-1:0]     out_length,
    output logic [lbb_pkg::BKT_W-1:0]     out_bucket,
    output logic                          last_of_batch
);

    // command and status between the controller and datapath
    lbb_pkg::cmd_t    cmd;
    lbb_pkg::status_t status;

    lbb_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .out_ready (out_ready),
        .status    (status),
        .cmd       (cmd),
        .in_ready  (in_ready),
        .out_valid (out_valid)
    );

    lbb_datapath
    #(
        .NUM_BUCKETS (NUM_BUCKETS),
        .BATCH_MAX   (BATCH_MAX)
    )
    u_datapath
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .item_length   (item_length),
        .item_tag      (item_tag),
        .cmd           (cmd),
        .status        (status),
        .out_tag       (out_tag),
        .out_length    (out_length),
        .out_bucket    (out_bucket),
        .last_of_batch (last_of_batch)
    );

endmodule

// File: rtl/lbb_ctrl.sv
// Controller state machine of the length bucket batcher.
`timescale 1ns / 1ps
module lbb_ctrl
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    input  logic            out_ready,
    input  lbb_pkg::status_t status,
    output lbb_pkg::cmd_t    cmd,
    output logic            in_ready,
    output logic            out_valid
);

    lbb_pkg::state_t state_reg;
    lbb_pkg::state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= lbb_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            lbb_pkg::ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = lbb_pkg::ST_MATCH;
                end
            end
            lbb_pkg::ST_MATCH:
            begin
                if (status.hit && status.emit)
                begin
                    state_next = lbb_pkg::ST_SCAN_START;
                end
                else
                begin
                    state_next = lbb_pkg::ST_IDLE;
                end
            end
            lbb_pkg::ST_SCAN_START:
            begin
                state_next = lbb_pkg::ST_SCAN;
            end
            lbb_pkg::ST_SCAN:
            begin
                if (status.scan_done)
                begin
                    state_next = lbb_pkg::ST_OUT;
                end
            end
            lbb_pkg::ST_OUT:
            begin
                if (out_ready)
                begin
                    state_next = status.last ? lbb_pkg::ST_IDLE : lbb_pkg::ST_SCAN_START;
                end
            end
            default:
            begin
                state_next = lbb_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        cmd       = '0;
        in_ready  = 1'b0;
        out_valid = 1'b0;
        case (state_reg)
            lbb_pkg::ST_IDLE:
            begin
                in_ready    = 1'b1;
                cmd.capture = in_valid;
            end
            lbb_pkg::ST_MATCH:
            begin
                cmd.commit = 1'b1;
            end
            lbb_pkg::ST_SCAN_START:
            begin
                cmd.scan_start = 1'b1;
            end
            lbb_pkg::ST_SCAN:
            begin
                cmd.scan_step = 1'b1;
            end
            lbb_pkg::ST_OUT:
            begin
                out_valid = 1'b1;
                cmd.pop   = out_ready;
            end
            default:
            begin
                cmd = '0;
            end
        endcase
    end

endmodule

// File: rtl/lbb_datapath.sv
// Datapath: config registers, bucket matching, entry store and batch selection scan.
`timescale 1ns / 1ps
module lbb_datapath
#(
    parameter int NUM_BUCKETS = lbb_pkg::NUM_BUCKETS_DEF,
    parameter int BATCH_MAX   = lbb_pkg::BATCH_MAX_DEF
)
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_we,
    input  logic [lbb_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [lbb_pkg::RULE_W-1:0]     cfg_data,
    input  logic [lbb_pkg::LEN_W-1:0]      item_length,
    input  logic [lbb_pkg::TAG_W-1:0]      item_tag,
    input  lbb_pkg::cmd_t                  cmd,
    output lbb_pkg::status_t               status,
    output logic [lbb_pkg::TAG_W-1:0]      out_tag,
    output logic [lbb_pkg::LEN_W-1:0]      out_length,
    output logic [lbb_pkg::BKT_W-1:0]      out_bucket,
    output logic                           last_of_batch
);

    localparam int NB_EFF = (NUM_BUCKETS < lbb_pkg::RULE_REGS) ? NUM_BUCKETS
                                                              : lbb_pkg::RULE_REGS;
    localparam int DEPTH  = NUM_BUCKETS * BATCH_MAX;
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int IDX_W  = (BATCH_MAX > 1) ? $clog2(BATCH_MAX) : 1;
    localparam int FILL_W = $clog2(BATCH_MAX + 1);
    localparam int ENT_W  = lbb_pkg::LEN_W + lbb_pkg::TAG_W;

    // configuration
    logic [lbb_pkg::INUSE_W-1:0] in_use_reg;
    logic [lbb_pkg::RULE_W-1:0]  rule_reg [lbb_pkg::RULE_REGS];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_use_reg <= '0;
            for (int i = 0; i < lbb_pkg::RULE_REGS; i++)
            begin
                rule_reg[i] <= '0;
            end
        end
        else if (cfg_we)
        begin
            if (cfg_index == lbb_pkg::REG_BUCKET_IN_USE)
            begin
                in_use_reg <= cfg_data[lbb_pkg::INUSE_W-1:0];
            end
            else if (cfg_index >= lbb_pkg::REG_RULE_FIRST && cfg_index <= lbb_pkg::REG_RULE_LAST)
            begin
                rule_reg[2'(cfg_index - lbb_pkg::REG_RULE_FIRST)] <= cfg_data;
            end
        end
    end

    // captured request
    logic [lbb_pkg::LEN_W-1:0] len_reg;
    logic [lbb_pkg::TAG_W-1:0] tag_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            len_reg <= item_length;
            tag_reg <= item_tag;
        end
    end

    // first matching active bucket
    logic [lbb_pkg::INUSE_W-1:0] n_act;
    logic                        hit;
    logic [lbb_pkg::BKT_W-1:0]   hit_b;

    always_comb
    begin
        n_act = (in_use_reg > lbb_pkg::INUSE_W'(NB_EFF)) ? lbb_pkg::INUSE_W'(NB_EFF)
                                                         : in_use_reg;
        hit   = 1'b0;
        hit_b = '0;
        for (int i = lbb_pkg::RULE_REGS - 1; i >= 0; i--)
        begin
            if (lbb_pkg::INUSE_W'(i) < n_act
                && rule_reg[i][23:0] <= len_reg && len_reg < rule_reg[i][47:24])
            begin
                hit   = 1'b1;
                hit_b = lbb_pkg::BKT_W'(i);
            end
        end
    end

    // fill counts and write position
    logic [FILL_W-1:0]         fill_reg [lbb_pkg::RULE_REGS];
    logic [FILL_W-1:0]         wpos;
    logic [FILL_W-1:0]         new_fill;
    logic [lbb_pkg::CAP_W-1:0] cap_raw;
    logic [lbb_pkg::CAP_W:0]   cap;
    logic                      emit;

    always_comb
    begin
        wpos     = (fill_reg[hit_b] >= FILL_W'(BATCH_MAX)) ? FILL_W'(BATCH_MAX - 1)
                                                           : fill_reg[hit_b];
        new_fill = wpos + 1'b1;
        cap_raw  = rule_reg[hit_b][52:48];
        cap      = {1'b0, cap_raw};
        if (cap_raw == '0)
        begin
            cap = (lbb_pkg::CAP_W + 1)'(1);
        end
        else if (cap > (lbb_pkg::CAP_W + 1)'(BATCH_MAX))
        begin
            cap = (lbb_pkg::CAP_W + 1)'(BATCH_MAX);
        end
        emit = (lbb_pkg::CAP_W + 1)'(new_fill) >= cap;
    end

    logic [lbb_pkg::BKT_W-1:0] cur_b_reg;
    logic [FILL_W-1:0]         cur_fill_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < lbb_pkg::RULE_REGS; i++)
            begin
                fill_reg[i] <= '0;
            end
        end
        else if (cmd.commit && hit)
        begin
            fill_reg[hit_b] <= emit ? '0 : new_fill;
        end
    end

    // entry store
    logic [ENT_W-1:0]  mem [DEPTH];
    logic [ADDR_W-1:0] waddr;
    logic [ADDR_W-1:0] raddr;
    logic [ENT_W-1:0]  rd_data_reg;
    logic [FILL_W-1:0] scan_idx_reg;

    assign waddr = ADDR_W'(32'(hit_b) * 32'(BATCH_MAX) + 32'(wpos));
    assign raddr = ADDR_W'(32'(cur_b_reg) * 32'(BATCH_MAX) + 32'(scan_idx_reg));

    always_ff @(posedge clk)
    begin
        if (cmd.commit && hit)
        begin
            mem[waddr] <= {len_reg, tag_reg};
        end
        rd_data_reg <= mem[raddr];
    end

    // selection scan: largest length, earliest index among entries not yet sent
    logic                      pend_reg;
    logic [IDX_W-1:0]          pidx_reg;
    logic [BATCH_MAX-1:0]      sent_reg;
    logic [FILL_W-1:0]         pos_reg;
    logic                      best_valid_reg;
    logic [lbb_pkg::LEN_W-1:0] best_len_reg;
    logic [lbb_pkg::TAG_W-1:0] best_tag_reg;
    logic [IDX_W-1:0]          best_idx_reg;
    logic [lbb_pkg::LEN_W-1:0] cand_len;
    logic                      take;
    logic                      more;

    assign cand_len = rd_data_reg[ENT_W-1:lbb_pkg::TAG_W];
    assign take     = pend_reg && !sent_reg[pidx_reg]
                      && (!best_valid_reg || cand_len > best_len_reg);
    assign more     = scan_idx_reg < cur_fill_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_reg       <= 1'b0;
            best_valid_reg <= 1'b0;
        end
        else if (cmd.scan_start)
        begin
            pend_reg       <= 1'b0;
            best_valid_reg <= 1'b0;
        end
        else if (cmd.scan_step)
        begin
            pend_reg <= more;
            if (take)
            begin
                best_valid_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.commit && hit && emit)
        begin
            cur_b_reg    <= hit_b;
            cur_fill_reg <= new_fill;
            sent_reg     <= '0;
            pos_reg      <= '0;
        end
        if (cmd.scan_start)
        begin
            scan_idx_reg <= '0;
        end
        else if (cmd.scan_step)
        begin
            if (more)
            begin
                scan_idx_reg <= scan_idx_reg + 1'b1;
                pidx_reg     <= IDX_W'(scan_idx_reg);
            end
            if (take)
            begin
                best_len_reg <= cand_len;
                best_tag_reg <= rd_data_reg[lbb_pkg::TAG_W-1:0];
                best_idx_reg <= pidx_reg;
            end
        end
        if (cmd.pop)
        begin
            sent_reg[best_idx_reg] <= 1'b1;
            pos_reg                <= pos_reg + 1'b1;
        end
    end

    assign status.hit       = hit;
    assign status.emit      = emit;
    assign status.scan_done = !more && !pend_reg;
    assign status.last      = (pos_reg + 1'b1) == cur_fill_reg;

    assign out_tag       = best_tag_reg;
    assign out_length    = best_len_reg;
    assign out_bucket    = cur_b_reg;
    assign last_of_batch = status.last;

endmodule

// File: rtl/lbb_checker.sv
// Port-level checker of the length bucket batcher, bound to the top level.
`timescale 1ns / 1ps
module lbb_checker
(
    input logic                      clk,
    input logic                      rst_n,
    input logic                      in_valid,
    input logic                      in_ready,
    input logic                      out_valid,
    input logic                      out_ready,
    input logic [lbb_pkg::TAG_W-1:0] out_tag,
    input logic [lbb_pkg::LEN_W-1:0] out_length,
    input logic                      last_of_batch
);

    // never accept while a batch member is pending
    a_excl: assert property (@(posedge clk) disable iff (!rst_n)
        !(in_ready && out_valid))
        else $error("in_ready and out_valid both high");

    // one item at a time: accepted request drops ready next cycle
    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> !in_ready)
        else $error("ready after accept");

    // mid-batch, no new input is taken
    a_batch: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_ready && !last_of_batch) |=> !in_ready)
        else $error("input taken inside batch");

    // stalled member holds
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=> (out_valid && $stable(out_tag)
                                       && $stable(out_length)))
        else $error("output changed under stall");

endmodule

bind length_bucket_batcher_unit lbb_checker u_lbb_checker
(
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_tag       (out_tag),
    .out_length    (out_length),
    .last_of_batch (last_of_batch)
);
